/* sv/imu_complementary_tilt_filter_unit_macros.svh */
// Assertion macros shared by the tilt filter RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef IMU_COMPLEMENTARY_TILT_FILTER_UNIT_MACROS_SVH
`define IMU_COMPLEMENTARY_TILT_FILTER_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define ICTF_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("tilt filter assertion failed");
`define ICTF_ASSERT_NR(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("tilt filter assertion failed");
`else
`define ICTF_ASSERT(lbl, prop)
`define ICTF_ASSERT_NR(lbl, prop)
`endif
`endif

/* sv/ictf_pkg.sv */
// Types, constants and the arctangent table of the tilt filter.
// No dependencies; imported by every module of the block.
package ictf_pkg;

    localparam int DW = 27;             // CORDIC datapath width
    localparam int TW = 5;              // arctangent table index width
    localparam int MAW = 36;            // multiplier operand A width
    localparam int MBW = 31;            // multiplier operand B width
    localparam int PW = MAW + MBW;      // product width
    localparam int NW = 53;             // signed dividend width
    localparam int QW = 34;             // signed quotient width
    localparam int DIV_BITS = 33;       // unsigned quotient magnitude width
    localparam int REM_W = 24;          // remainder width before the fix-up
    localparam int RECIP_SHIFT = 29;    // product shift of the quotient estimate
    localparam logic [19:0] US_PER_S = 20'd1000000;
    localparam logic [MBW-1:0] KINV_Q30 = 31'd652032874;
    // floor(2^49 / 1000000): the estimate never exceeds the true quotient.
    localparam logic [MBW-1:0] RECIP_US = 31'd562949953;

    typedef struct packed {
        logic mul_go;
        logic div_go;
    } t_arith_ctl;

    typedef struct packed {
        logic div_busy;
        logic div_done;
    } t_arith_sts;

    function automatic logic [21:0] atan_deg(input logic [TW-1:0] idx);
        logic [21:0] v;
        case (idx)
            5'd0: v = 22'd2949120;
            5'd1: v = 22'd1740967;
            5'd2: v = 22'd919879;
            5'd3: v = 22'd466945;
            5'd4: v = 22'd234379;
            5'd5: v = 22'd117304;
            5'd6: v = 22'd58665;
            5'd7: v = 22'd29335;
            5'd8: v = 22'd14668;
            5'd9: v = 22'd7334;
            5'd10: v = 22'd3667;
            5'd11: v = 22'd1833;
            5'd12: v = 22'd917;
            5'd13: v = 22'd458;
            5'd14: v = 22'd229;
            5'd15: v = 22'd115;
            5'd16: v = 22'd57;
            5'd17: v = 22'd29;
            5'd18: v = 22'd14;
            5'd19: v = 22'd7;
            5'd20: v = 22'd4;
            5'd21: v = 22'd2;
            5'd22: v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage

/* sv/ictf_cordic.sv */
// Iterative vectoring CORDIC, one micro-rotation per cycle.
// Depends on ictf_pkg for widths and the arctangent table.
module ictf_cordic #(
    parameter int STEPS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic signed [ictf_pkg::DW-1:0] i_x0,
    input  logic signed [ictf_pkg::DW-1:0] i_y0,
    output logic signed [ictf_pkg::DW-1:0] o_x,
    output logic signed [ictf_pkg::DW-1:0] o_ang,
    output logic                         o_done
);
    import ictf_pkg::*;

    localparam int CW = $clog2(STEPS + 1);

    logic signed [DW-1:0] r_x, r_y, r_ang;
    logic [CW-1:0]        r_cnt;
    logic                 r_busy, r_done;
    logic signed [DW-1:0] w_xs, w_ys, w_tab;

    assign w_xs  = r_x >>> r_cnt;
    assign w_ys  = r_y >>> r_cnt;
    assign w_tab = DW'(atan_deg(TW'(r_cnt)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_x    <= i_x0;
                r_y    <= i_y0;
                r_ang  <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_y[DW-1]) begin
                    r_x   <= r_x - w_ys;
                    r_y   <= r_y + w_xs;
                    r_ang <= r_ang - w_tab;
                end else begin
                    r_x   <= r_x + w_ys;
                    r_y   <= r_y - w_xs;
                    r_ang <= r_ang + w_tab;
                end
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_x    = r_x;
    assign o_ang  = r_ang;
    assign o_done = r_done;
endmodule

/* sv/ictf_arith.sv */
// Shared signed multiplier with a registered product, and a floor divider by one
// million built on reciprocal multiplication through that multiplier. Depends on ictf_pkg.
module ictf_arith (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ictf_pkg::t_arith_ctl          i_ctl,
    input  logic signed [ictf_pkg::MAW-1:0] i_a,
    input  logic signed [ictf_pkg::MBW-1:0] i_b,
    input  logic signed [ictf_pkg::NW-1:0]  i_num,
    output logic signed [ictf_pkg::PW-1:0]  o_prod,
    output logic signed [ictf_pkg::QW-1:0]  o_quot,
    output ictf_pkg::t_arith_sts          o_sts
);
    import ictf_pkg::*;

    typedef enum logic [2:0] {
        D_IDLE, D_MUL1, D_QEST, D_MUL2, D_REM, D_FIX
    } t_dstate;

    t_dstate              r_dst;
    logic signed [PW-1:0] r_prod;
    logic [NW-2:0]        r_mag;
    logic [DIV_BITS-1:0]  r_q;
    logic [REM_W-1:0]     r_rem;
    logic                 r_neg, r_done;
    logic [NW-2:0]        w_mag;
    logic signed [MAW-1:0] w_a;
    logic signed [MBW-1:0] w_b;
    logic                 w_mul;
    logic [QW-1:0]        w_qe;

    assign w_mag = i_num[NW-1] ? (NW-1)'(-i_num) : i_num[NW-2:0];

    // While dividing, the sequencer leaves the multiplier idle and the divider
    // borrows it: first the upper dividend bits times the reciprocal, then the
    // quotient estimate times one million.
    always_comb begin
        w_a   = i_a;
        w_b   = i_b;
        w_mul = i_ctl.mul_go;
        case (r_dst)
            D_MUL1: begin
                w_a   = MAW'(r_mag[NW-2:NW-33]);
                w_b   = RECIP_US;
                w_mul = 1'b1;
            end
            D_MUL2: begin
                w_a   = MAW'(r_q);
                w_b   = MBW'(US_PER_S);
                w_mul = 1'b1;
            end
            default: begin
                w_mul = i_ctl.mul_go;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_mul) begin
            r_prod <= w_a * w_b;
        end
    end

    // The estimate is at most ten below the true quotient, so the remainder
    // fix-up subtracts one million at most ten times.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dst  <= D_IDLE;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_dst)
                D_IDLE: begin
                    if (i_ctl.div_go) begin
                        r_neg <= i_num[NW-1];
                        r_mag <= w_mag;
                        r_dst <= D_MUL1;
                    end
                end
                D_MUL1: r_dst <= D_QEST;
                D_QEST: begin
                    r_q   <= r_prod[RECIP_SHIFT+DIV_BITS-1:RECIP_SHIFT];
                    r_dst <= D_MUL2;
                end
                D_MUL2: r_dst <= D_REM;
                D_REM: begin
                    r_rem <= REM_W'(r_mag - r_prod[NW-2:0]);
                    r_dst <= D_FIX;
                end
                D_FIX: begin
                    if (r_rem >= REM_W'(US_PER_S)) begin
                        r_rem <= r_rem - REM_W'(US_PER_S);
                        r_q   <= r_q + 1'b1;
                    end else begin
                        r_dst  <= D_IDLE;
                        r_done <= 1'b1;
                    end
                end
                default: r_dst <= D_IDLE;
            endcase
        end
    end

    // Floor of a negative quotient steps one further when a remainder is left.
    assign w_qe   = QW'(r_q) + QW'(r_rem != '0);
    assign o_quot = !r_neg ? QW'(r_q) : -w_qe;
    assign o_prod = r_prod;
    assign o_sts  = '{div_busy: (r_dst != D_IDLE), div_done: r_done};
endmodule

/* sv/imu_complementary_tilt_filter_unit.sv */
// Each transaction runs two CORDIC passes per tilt (a zero vector skips the second) and, per gyro
// axis, a reciprocal multiply divide with a remainder fix-up. The block takes no new transaction
// before the last is done; the input stalls until the result is parked in the output register.
// Synchronous active-low reset restores register defaults and clears kept angles.
// Depends on ictf_pkg, ictf_cordic, ictf_arith and the assertion macro header.
`include "imu_complementary_tilt_filter_unit_macros.svh"
module imu_complementary_tilt_filter_unit #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [15:0] i_accel_x,
    input  logic signed [15:0] i_accel_y,
    input  logic signed [15:0] i_accel_z,
    input  logic signed [15:0] i_gyro_x,
    input  logic signed [15:0] i_gyro_y,
    input  logic signed [15:0] i_gyro_z,
    input  logic [19:0]        i_elapsed_us,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_roll,
    output logic signed [31:0] o_pitch,
    output logic signed [31:0] o_yaw,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import ictf_pkg::*;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_ROLL_OFF  = 3'd0;
    localparam logic [2:0] REG_PITCH_OFF = 3'd1;
    localparam logic [2:0] REG_GOFS_X    = 3'd2;
    localparam logic [2:0] REG_GOFS_Y    = 3'd3;
    localparam logic [2:0] REG_GOFS_Z    = 3'd4;
    localparam logic [2:0] REG_GAIN      = 3'd5;
    localparam logic [2:0] REG_BLEND     = 3'd6;

    typedef enum logic [4:0] {
        S_IDLE, S_C1, S_C1W, S_KM, S_KMW, S_C2W,
        S_GM1, S_GM1W, S_GM2, S_GM2W, S_DVW,
        S_BM1, S_BM1W, S_BM2, S_BM2W, S_OUT
    } t_state;

    t_state r_st;

    // Configuration registers.
    logic signed [24:0] r_roll_off, r_pitch_off;
    logic signed [27:0] r_gofs [3];
    logic [23:0]        r_gain;
    logic [15:0]        r_blend;

    // Captured transaction and working values.
    logic signed [15:0] r_acc [3];
    logic signed [15:0] r_gyr [3];
    logic [19:0]        r_us;
    logic [1:0]         r_sel;
    logic signed [DW-1:0] r_tilt [2];
    logic signed [QW-1:0] r_step [3];
    logic signed [31:0] r_kept [3];
    logic signed [31:0] r_res [2];
    logic signed [33:0] r_rate;
    logic signed [51:0] r_bacc;
    logic               r_ovalid;
    logic signed [31:0] r_oroll, r_opitch, r_oyaw;

    // Shared unit hookup.
    t_arith_ctl           w_ctl;
    t_arith_sts           w_sts;
    logic signed [MAW-1:0] w_ma;
    logic signed [MBW-1:0] w_mb;
    logic signed [PW-1:0]  w_prod;
    logic signed [QW-1:0]  w_quot;
    logic                 w_cstart, w_cdone;
    logic signed [DW-1:0] w_cx0, w_cy0, w_cx, w_cang;

    // Tilt operand selection: roll uses (y over |x,z|), pitch (-x over |y,z|).
    logic signed [15:0] w_p;
    logic signed [16:0] w_num, w_pabs;
    logic signed [DW-1:0] w_r, w_off, w_tilt_raw;
    logic signed [52:0] w_bsum;
    logic signed [36:0] w_f;
    logic signed [31:0] w_sat;
    logic               w_wr, w_load;

    assign w_p    = (r_sel == 2'd0) ? r_acc[0] : r_acc[1];
    assign w_num  = (r_sel == 2'd0) ? 17'(r_acc[1]) : -17'(r_acc[0]);
    assign w_pabs = w_p[15] ? -17'(w_p) : 17'(w_p);
    assign w_off  = (r_sel == 2'd0) ? DW'(r_roll_off) : DW'(r_pitch_off);
    assign w_r    = w_prod[56:30];

    ictf_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_cstart),
        .i_x0   (w_cx0),
        .i_y0   (w_cy0),
        .o_x    (w_cx),
        .o_ang  (w_cang),
        .o_done (w_cdone)
    );

    ictf_arith u_arith (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (w_ctl),
        .i_a    (w_ma),
        .i_b    (w_mb),
        .i_num  (w_prod[NW-1:0]),
        .o_prod (w_prod),
        .o_quot (w_quot),
        .o_sts  (w_sts)
    );

    // The first pass starts from (|p|, z) scaled by 256; the second from the
    // gain-corrected magnitude and the numerator scaled by 256.
    always_comb begin
        w_cstart = 1'b0;
        w_cx0    = DW'(w_pabs) <<< 8;
        w_cy0    = DW'(r_acc[2]) <<< 8;
        if (r_st == S_C1) begin
            w_cstart = 1'b1;
        end else if (r_st == S_KMW && !(w_r == '0 && w_num == '0)) begin
            w_cstart = 1'b1;
            w_cx0    = w_r;
            w_cy0    = DW'(w_num) <<< 8;
        end
    end

    // Multiplier operands for each step of the sequence.
    always_comb begin
        w_ctl = '{mul_go: 1'b0, div_go: 1'b0};
        w_ma  = MAW'(w_cx);
        w_mb  = KINV_Q30;
        case (r_st)
            S_KM: begin
                w_ctl.mul_go = 1'b1;
            end
            S_GM1: begin
                w_ctl.mul_go = 1'b1;
                w_ma = MAW'(r_gyr[r_sel]);
                w_mb = MBW'({1'b0, r_gain});
            end
            S_GM2: begin
                w_ctl.mul_go = 1'b1;
                w_ma = MAW'(r_rate);
                w_mb = MBW'({1'b0, r_us});
            end
            S_GM2W: begin
                w_ctl.div_go = 1'b1;
            end
            S_BM1: begin
                w_ctl.mul_go = 1'b1;
                w_ma = MAW'(r_kept[r_sel]) + MAW'(r_step[r_sel]);
                w_mb = MBW'({1'b0, r_blend});
            end
            S_BM2: begin
                w_ctl.mul_go = 1'b1;
                w_ma = MAW'(r_tilt[r_sel[0]]);
                w_mb = MBW'(18'sd65536 - 18'(r_blend));
            end
            default: begin
                w_ctl = '{mul_go: 1'b0, div_go: 1'b0};
            end
        endcase
    end

    // A zero vector gives a zero tilt before the offset is taken off.
    assign w_tilt_raw = (r_st == S_KMW) ? '0 : w_cang;

    // Blend: weighted sum, floor shift by 16, then saturate to 32 bits.
    assign w_bsum = 53'(r_bacc) + 53'($signed(w_prod[51:0]));
    assign w_f    = w_bsum[52:16];
    always_comb begin
        if (w_f > 37'sd2147483647) begin
            w_sat = 32'sh7fffffff;
        end else if (w_f < -37'sd2147483648) begin
            w_sat = 32'sh80000000;
        end else begin
            w_sat = w_f[31:0];
        end
    end

    assign w_wr   = psel && penable && pwrite;
    assign w_load = (r_st == S_OUT) && (!r_ovalid || !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_roll_off  <= 25'sd25;
            r_pitch_off <= -25'sd13626;
            r_gofs[0]   <= 28'sd22740;
            r_gofs[1]   <= 28'sd42018;
            r_gofs[2]   <= -28'sd18473;
            r_gain      <= 24'd128070;
            r_blend     <= 16'd62915;
        end else if (w_wr) begin
            case (paddr[4:2])
                REG_ROLL_OFF:  r_roll_off  <= pwdata[24:0];
                REG_PITCH_OFF: r_pitch_off <= pwdata[24:0];
                REG_GOFS_X:    r_gofs[0]   <= pwdata[27:0];
                REG_GOFS_Y:    r_gofs[1]   <= pwdata[27:0];
                REG_GOFS_Z:    r_gofs[2]   <= pwdata[27:0];
                REG_GAIN:      r_gain      <= pwdata[23:0];
                REG_BLEND:     r_blend     <= pwdata[15:0];
                default:       r_blend     <= r_blend;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_ROLL_OFF:  prdata = 32'({7'd0, r_roll_off});
            REG_PITCH_OFF: prdata = 32'({7'd0, r_pitch_off});
            REG_GOFS_X:    prdata = 32'({4'd0, r_gofs[0]});
            REG_GOFS_Y:    prdata = 32'({4'd0, r_gofs[1]});
            REG_GOFS_Z:    prdata = 32'({4'd0, r_gofs[2]});
            REG_GAIN:      prdata = 32'(r_gain);
            REG_BLEND:     prdata = 32'(r_blend);
            default:       prdata = '0;
        endcase
    end
    assign pready = 1'b1;

    // Sequencer: roll tilt, pitch tilt, three gyro steps, two blends, result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st      <= S_IDLE;
            r_sel     <= '0;
            r_ovalid  <= 1'b0;
            r_kept[0] <= '0;
            r_kept[1] <= '0;
            r_kept[2] <= '0;
        end else begin
            if (r_ovalid && !i_stall && !w_load) begin
                r_ovalid <= 1'b0;
            end
            case (r_st)
                S_IDLE: begin
                    if (i_valid) begin
                        r_acc[0] <= i_accel_x;
                        r_acc[1] <= i_accel_y;
                        r_acc[2] <= i_accel_z;
                        r_gyr[0] <= i_gyro_x;
                        r_gyr[1] <= i_gyro_y;
                        r_gyr[2] <= i_gyro_z;
                        r_us     <= i_elapsed_us;
                        r_sel    <= 2'd0;
                        r_st     <= S_C1;
                    end
                end
                S_C1: r_st <= S_C1W;
                S_C1W: begin
                    if (w_cdone) begin
                        r_st <= S_KM;
                    end
                end
                S_KM: r_st <= S_KMW;
                S_KMW: begin
                    if (w_r == '0 && w_num == '0) begin
                        r_tilt[r_sel[0]] <= w_tilt_raw - w_off;
                        r_sel <= (r_sel == 2'd0) ? 2'd1 : 2'd0;
                        r_st  <= (r_sel == 2'd0) ? S_C1 : S_GM1;
                    end else begin
                        r_st <= S_C2W;
                    end
                end
                S_C2W: begin
                    if (w_cdone) begin
                        r_tilt[r_sel[0]] <= w_tilt_raw - w_off;
                        r_sel <= (r_sel == 2'd0) ? 2'd1 : 2'd0;
                        r_st  <= (r_sel == 2'd0) ? S_C1 : S_GM1;
                    end
                end
                S_GM1: r_st <= S_GM1W;
                S_GM1W: begin
                    r_rate <= 34'($signed(w_prod[40:8])) - 34'(r_gofs[r_sel]);
                    r_st   <= S_GM2;
                end
                S_GM2: r_st <= S_GM2W;
                S_GM2W: r_st <= S_DVW;
                S_DVW: begin
                    if (w_sts.div_done) begin
                        r_step[r_sel] <= w_quot;
                        r_sel <= (r_sel == 2'd2) ? 2'd0 : r_sel + 2'd1;
                        r_st  <= (r_sel == 2'd2) ? S_BM1 : S_GM1;
                    end
                end
                S_BM1: r_st <= S_BM1W;
                S_BM1W: begin
                    r_bacc <= w_prod[51:0];
                    r_st   <= S_BM2;
                end
                S_BM2: r_st <= S_BM2W;
                S_BM2W: begin
                    r_res[r_sel[0]] <= w_sat;
                    r_sel <= (r_sel == 2'd0) ? 2'd1 : 2'd0;
                    r_st  <= (r_sel == 2'd0) ? S_BM1 : S_OUT;
                end
                S_OUT: begin
                    if (w_load) begin
                        r_oroll   <= r_res[0];
                        r_opitch  <= r_res[1];
                        r_oyaw    <= r_kept[2] + r_step[2][31:0];
                        r_kept[0] <= r_res[0];
                        r_kept[1] <= r_res[1];
                        r_kept[2] <= r_kept[2] + r_step[2][31:0];
                        r_ovalid  <= 1'b1;
                        r_st      <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign o_stall = (r_st != S_IDLE);
    assign o_valid = r_ovalid;
    assign o_roll  = r_oroll;
    assign o_pitch = r_opitch;
    assign o_yaw   = r_oyaw;

    // An accepted transaction always holds off the next one.
    `ICTF_ASSERT(a_accept_stalls, (i_valid && !o_stall) |=> o_stall)
    // The CORDIC only finishes while the sequencer waits for it.
    `ICTF_ASSERT(a_cordic_done_expected, w_cdone |-> (r_st == S_C1W || r_st == S_C2W))
    // The divider only runs while the sequencer waits for its quotient.
    `ICTF_ASSERT(a_div_busy_expected, w_sts.div_busy |-> (r_st == S_DVW))
endmodule
